### design/dq_pkg.sv
// Package: item types, command codes and controller types for the circular deque.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH   = 1024;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] push_value;
  } dq_op_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic                      pop_missed;
    logic                      push_refused;
    logic [COUNT_W-1:0]        element_count;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
  } dq_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SEND
  } dq_state_t;

  typedef struct packed {
    logic load_op;
    logic exec;
    logic load_fetch;
  } dq_ctl_t;

  typedef struct packed {
    logic need_fetch;
  } dq_status_t;

endpackage

### design/dq_ctrl.sv
// Controller: sequences accept, execute, memory fetch and result hand-off.
`timescale 1ns / 1ps
module dq_ctrl import dq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  output logic       op_stall,
  output logic       res_valid,
  input  logic       res_stall,
  input  dq_status_t status,
  output dq_ctl_t    ctl
);

  dq_state_t state;
  dq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    op_stall       = 1'b1;
    res_valid      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        op_stall = 1'b0;
        if (op_valid) begin
          ctl.load_op = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = status.need_fetch ? ST_FETCH : ST_SEND;
      end
      ST_FETCH: begin
        ctl.load_fetch = 1'b1;
        state_next     = ST_SEND;
      end
      ST_SEND: begin
        res_valid = 1'b1;
        if (!res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/dq_datapath.sv
// Datapath: element memory, head and tail pointers, count and result registers.
`timescale 1ns / 1ps
module dq_datapath import dq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dq_op_t     op,
  input  dq_ctl_t    ctl,
  output dq_status_t status,
  output dq_res_t    res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic                      mem_we;

  dq_op_t                    op_reg;
  logic [AW-1:0]             head;
  logic [AW-1:0]             tail;
  logic [CW-1:0]             count;
  logic signed [VALUE_W-1:0] front_val;
  logic signed [VALUE_W-1:0] back_val;
  logic signed [VALUE_W-1:0] popped;
  logic                      missed;
  logic                      refused;
  logic                      fetch_front;

  logic                      is_push;
  logic                      is_pop;
  logic [AW-1:0]             head_inc;
  logic [AW-1:0]             head_dec;
  logic [AW-1:0]             tail_inc;
  logic [AW-1:0]             tail_dec;
  logic [AW-1:0]             tail_dec2;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_PTR : p - AW'(1);
  endfunction

  always_comb begin
    is_push   = (op_reg.cmd == CMD_PUSH_FRONT) || (op_reg.cmd == CMD_PUSH_BACK);
    is_pop    = (op_reg.cmd == CMD_POP_FRONT) || (op_reg.cmd == CMD_POP_BACK);
    head_inc  = ptr_inc(head);
    head_dec  = ptr_dec(head);
    tail_inc  = ptr_inc(tail);
    tail_dec  = ptr_dec(tail);
    tail_dec2 = ptr_dec(tail_dec);
    status.need_fetch = is_pop && (count > CW'(1));
    mem_we  = ctl.exec && is_push && (count != FULL_CNT);
    wr_addr = (op_reg.cmd == CMD_PUSH_FRONT) ? head_dec : tail;
    rd_addr = (op_reg.cmd == CMD_POP_FRONT) ? head_inc : tail_dec2;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= op_reg.push_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_op) begin
      op_reg <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      if (is_push && (count != FULL_CNT)) begin
        count <= count + CW'(1);
        if (op_reg.cmd == CMD_PUSH_FRONT) begin
          head <= head_dec;
        end else begin
          tail <= tail_inc;
        end
      end else if (is_pop && (count != '0)) begin
        count <= count - CW'(1);
        if (op_reg.cmd == CMD_POP_FRONT) begin
          head <= head_inc;
        end else begin
          tail <= tail_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      popped      <= NONE_VALUE;
      missed      <= 1'b0;
      refused     <= 1'b0;
      fetch_front <= (op_reg.cmd == CMD_POP_FRONT);
      if (is_push) begin
        if (count == FULL_CNT) begin
          refused <= 1'b1;
        end else if (op_reg.cmd == CMD_PUSH_FRONT) begin
          front_val <= op_reg.push_value;
          if (count == '0) begin
            back_val <= op_reg.push_value;
          end
        end else begin
          back_val <= op_reg.push_value;
          if (count == '0) begin
            front_val <= op_reg.push_value;
          end
        end
      end else if (is_pop) begin
        if (count == '0) begin
          missed <= 1'b1;
        end else if (op_reg.cmd == CMD_POP_FRONT) begin
          popped <= front_val;
        end else begin
          popped <= back_val;
        end
      end
    end else if (ctl.load_fetch) begin
      if (fetch_front) begin
        front_val <= rd_data;
      end else begin
        back_val <= rd_data;
      end
    end
  end

  always_comb begin
    res.popped_value  = popped;
    res.pop_missed    = missed;
    res.push_refused  = refused;
    res.element_count = COUNT_W'(count);
    res.is_empty      = (count == '0);
    res.front_value   = (count == '0) ? NONE_VALUE : front_val;
    res.back_value    = (count == '0) ? NONE_VALUE : back_val;
  end

endmodule

### design/circular_double_ended_queue_top.sv
// Top level: circular double-ended queue with push/pop at both ends.
// Each item is one command (push front, push back, pop front, pop back, or
// query; codes 5 to 7 act as query). One item is handled at a time: the item
// is taken in IDLE, executed in EXEC in the next cycle, and its result is
// offered in SEND in the cycle after that; a pop that leaves elements behind
// passes through FETCH between EXEC and SEND; a stalled result stays in SEND.
// FETCH loads the registered read of the element memory that fetches the new
// front or back element. A push into a full queue is refused and flagged; a
// pop from an empty queue returns -1 and is flagged. Front and back read -1
// when the queue is empty. The element memory needs no clearing after reset.
`timescale 1ns / 1ps
module circular_double_ended_queue_top import dq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  output logic    op_stall,
  input  dq_op_t  op,
  output logic    res_valid,
  input  logic    res_stall,
  output dq_res_t res
);

  dq_ctl_t    ctl;
  dq_status_t status;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .ctl       (ctl)
  );

  dq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .ctl    (ctl),
    .status (status),
    .res    (res)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> op_stall)
    else $error("item accepted while a result is pending");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> !res_valid)
    else $error("result offered before execution");

  a_miss_means_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.pop_missed) |-> (res.is_empty && !res.push_refused))
    else $error("pop miss reported with elements present");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_empty) |->
      (res.front_value == NONE_VALUE && res.back_value == NONE_VALUE))
    else $error("empty queue reports a front or back element");

endmodule
